[rtl/core/c3x3f_pkg.sv]
// shared types and constants of the 3x3 convolution filter
// sizes, register indexes and the configuration bundle; no dependencies
package c3x3f_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   localparam int PIXEL_W    = 8;
   localparam int COEF_W     = 8;
   localparam int ROWREG_W   = 24;
   localparam int SIZEREG_W  = 11;
   localparam int FILT_W     = 20;
   localparam int POS_W      = 10;
   localparam int PROD_W     = 17;
   localparam int SUM_W      = 21;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_COEF_TOP    = 3'd0,
      REG_COEF_MID    = 3'd1,
      REG_COEF_BOTTOM = 3'd2,
      REG_WIDTH       = 3'd3,
      REG_HEIGHT      = 3'd4
   } csr_index_type;

   typedef logic [2:0][COEF_W-1:0]        coef_row_type;
   typedef logic [2:0][PIXEL_W-1:0]       pixel_col_type;

   typedef struct packed {
      coef_row_type [2:0] coef;
      logic [COL_W-1:0]   last_col;
      logic [ROW_W-1:0]   last_row;
   } cfg_type;

   function automatic logic [COL_W-1:0] last_col_of(input logic [SIZEREG_W-1:0] v);
      logic [COL_W-1:0] res;
      if (int'(v) < 3) begin
         res = COL_W'(2);
      end else if (int'(v) > MAX_WIDTH) begin
         res = COL_W'(MAX_WIDTH - 1);
      end else begin
         res = COL_W'(int'(v) - 1);
      end
      return res;
   endfunction

   function automatic logic [ROW_W-1:0] last_row_of(input logic [SIZEREG_W-1:0] v);
      logic [ROW_W-1:0] res;
      if (int'(v) < 3) begin
         res = ROW_W'(2);
      end else if (int'(v) > MAX_HEIGHT) begin
         res = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         res = ROW_W'(int'(v) - 1);
      end
      return res;
   endfunction

endpackage

[rtl/core/c3x3f_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module c3x3f_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/c3x3f_csr.sv]
// configuration registers of the 3x3 filter behind an apb-style port
// depends on c3x3f_pkg
module c3x3f_csr
   import c3x3f_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [ROWREG_W-1:0]  coef_top_ff, coef_top_in;
   logic [ROWREG_W-1:0]  coef_mid_ff, coef_mid_in;
   logic [ROWREG_W-1:0]  coef_bot_ff, coef_bot_in;
   logic [SIZEREG_W-1:0] width_ff, width_in;
   logic [SIZEREG_W-1:0] height_ff, height_in;
   logic                 wr_en;
   csr_index_type        index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      coef_top_in = coef_top_ff;
      coef_mid_in = coef_mid_ff;
      coef_bot_in = coef_bot_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      if (wr_en) begin
         unique case (index)
            REG_COEF_TOP:    coef_top_in = pwdata[ROWREG_W-1:0];
            REG_COEF_MID:    coef_mid_in = pwdata[ROWREG_W-1:0];
            REG_COEF_BOTTOM: coef_bot_in = pwdata[ROWREG_W-1:0];
            REG_WIDTH:       width_in    = pwdata[SIZEREG_W-1:0];
            REG_HEIGHT:      height_in   = pwdata[SIZEREG_W-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= '0;
         coef_mid_ff <= '0;
         coef_bot_ff <= '0;
         width_ff    <= SIZEREG_W'(1024);
         height_ff   <= SIZEREG_W'(1024);
      end else begin
         coef_top_ff <= coef_top_in;
         coef_mid_ff <= coef_mid_in;
         coef_bot_ff <= coef_bot_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_COEF_TOP:    prdata = CSR_DATA_W'(coef_top_ff);
         REG_COEF_MID:    prdata = CSR_DATA_W'(coef_mid_ff);
         REG_COEF_BOTTOM: prdata = CSR_DATA_W'(coef_bot_ff);
         REG_WIDTH:       prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT:      prdata = CSR_DATA_W'(height_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.coef[0]  = coef_row_type'(coef_top_ff);
   assign cfg.coef[1]  = coef_row_type'(coef_mid_ff);
   assign cfg.coef[2]  = coef_row_type'(coef_bot_ff);
   assign cfg.last_col = last_col_of(width_ff);
   assign cfg.last_row = last_row_of(height_ff);

endmodule

[rtl/core/c3x3f_window.sv]
// 3x3 pixel window and the nine-tap signed multiply-add
// depends on c3x3f_pkg
module c3x3f_window
   import c3x3f_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  pixel_col_type     col_in,
   input  cfg_type           cfg,
   output logic [FILT_W-1:0] sum_out
);

   logic [2:0][2:0][PIXEL_W-1:0] win_ff, win_in;
   logic signed [PROD_W-1:0]     prod [3][3];
   logic signed [SUM_W-1:0]      prod_x [3][3];
   logic signed [SUM_W-1:0]      total;

   // shift left, new column enters on the right
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
         win_in[i][2] = col_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      logic signed [PROD_W-1:0] pix_x;
      logic signed [PROD_W-1:0] coef_x;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pix_x        = {{(PROD_W-PIXEL_W){1'b0}}, win_in[i][j]};
            coef_x       = {{(PROD_W-COEF_W){cfg.coef[i][j][COEF_W-1]}}, cfg.coef[i][j]};
            prod[i][j]   = pix_x * coef_x;
            prod_x[i][j] = {{(SUM_W-PROD_W){prod[i][j][PROD_W-1]}}, prod[i][j]};
         end
      end
   end

   assign total = ((prod_x[0][0] + prod_x[0][1]) + (prod_x[0][2] + prod_x[1][0]))
                + ((prod_x[1][1] + prod_x[1][2]) + (prod_x[2][0] + prod_x[2][1]))
                + prod_x[2][2];

   assign sum_out = total[FILT_W-1:0];

endmodule

[rtl/core/conv3x3_image_filter_unit.sv]
// top level of the 3x3 convolution filter: raster counters, line buffer ram, result register
// depends on c3x3f_pkg, c3x3f_csr, c3x3f_ram, c3x3f_window
//
//  channel  | ports                                    | moves
//  ---------+------------------------------------------+----------------------------------
//  req      | req_valid, req_stall, req_pixel          | one pixel, raster order
//  rsp      | rsp_valid, rsp_stall, rsp_filtered,      | one interior result with its
//           | rsp_out_row, rsp_out_col, rsp_last       | window centre and end-of-image flag
//  csr      | psel, penable, pwrite, paddr, pwdata,    | coefficient rows and image size
//           | prdata, pready                           |
//
// one pixel per cycle unless rsp_stall backs up; results pass s1, then the result register
// the line buffer ram (one read, one write per cycle) sets that rate
// reset clears counters, window and coefficients; line buffers start unwritten
// rsp_stall holds the result register and, once the stage behind it is full, raises req_stall
module conv3x3_image_filter_unit
   import c3x3f_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PIXEL_W-1:0]       req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [FILT_W-1:0] rsp_filtered,
   output logic [POS_W-1:0]         rsp_out_row,
   output logic [POS_W-1:0]         rsp_out_col,
   output logic                     rsp_last,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   localparam int LINE_W = 2 * PIXEL_W;

   cfg_type cfg;

   logic [COL_W-1:0]    col_count_ff, col_count_in;
   logic [ROW_W-1:0]    row_count_ff, row_count_in;
   logic                accept, row_end, img_end, produce;

   logic                s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]    s1_col_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic [PIXEL_W-1:0]  s1_pixel_ff;
   logic                s1_prod_ff, s1_last_ff;
   logic                s1_adv, out_free;

   logic [LINE_W-1:0]   ram_rd_data, ram_wr_data;
   pixel_col_type       new_col;
   logic [FILT_W-1:0]   sum_next;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FILT_W-1:0]   rsp_filtered_ff;
   logic [POS_W-1:0]    rsp_row_ff, rsp_col_ff;
   logic                rsp_last_ff;

   c3x3f_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake and stage control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_prod_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   // raster position
   assign row_end = col_count_ff >= cfg.last_col;
   assign img_end = row_end && (row_count_ff >= cfg.last_row);
   assign produce = (row_count_ff >= ROW_W'(2)) && (col_count_ff >= COL_W'(2));

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         priority if (img_end) begin
            col_count_in = '0;
            row_count_in = '0;
         end else if (row_end) begin
            col_count_in = '0;
            row_count_in = row_count_ff + ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col_count_ff;
         s1_row_ff   <= row_count_ff;
         s1_pixel_ff <= req_pixel;
         s1_prod_ff  <= produce;
         s1_last_ff  <= img_end;
      end
   end

   // line buffers: high byte two rows above, low byte one row above
   assign ram_wr_data = {ram_rd_data[PIXEL_W-1:0], s1_pixel_ff};

   c3x3f_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col_count_ff),
      .rd_data (ram_rd_data)
   );

   assign new_col[0] = ram_rd_data[LINE_W-1:PIXEL_W];
   assign new_col[1] = ram_rd_data[PIXEL_W-1:0];
   assign new_col[2] = s1_pixel_ff;

   c3x3f_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_adv),
      .col_in   (new_col),
      .cfg      (cfg),
      .sum_out  (sum_next)
   );

   // result register
   always_comb begin
      priority if (s1_adv && s1_prod_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_prod_ff) begin
         rsp_filtered_ff <= sum_next;
         rsp_row_ff      <= POS_W'(s1_row_ff - ROW_W'(1));
         rsp_col_ff      <= POS_W'(s1_col_ff - COL_W'(1));
         rsp_last_ff     <= s1_last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = $signed(rsp_filtered_ff);
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_last     = rsp_last_ff;

   // line buffer read and write never meet at one column
   a_no_ram_collision : assert property (@(posedge clock) disable iff (reset)
      (accept && s1_adv) |-> (col_count_ff != s1_col_ff))
      else $error("line buffer read and write hit the same column");

   // a held stage keeps its line buffer data
   a_ram_data_held : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> $stable(ram_rd_data))
      else $error("line buffer data changed under a held request");

   // counters restart after the last pixel of an image
   a_image_wrap : assert property (@(posedge clock) disable iff (reset)
      (accept && img_end) |=> (col_count_ff == '0) && (row_count_ff == '0))
      else $error("raster counters did not restart at end of image");

   // an interior request leaving the stage shows up as a result
   a_result_loaded : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_prod_ff) |=> rsp_valid)
      else $error("interior request produced no result");

endmodule

[verif/conv3x3_image_filter_unit_test.sv]
// self-checking testbench of the 3x3 convolution filter: pixel stream in, interior sums out
// a scoreboard class predicts every result and compares it; tasks drive pixels and registers
// depends on c3x3f_pkg and the conv3x3_image_filter_unit rtl
module conv3x3_image_filter_unit_test;
   import c3x3f_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned RANDOM_ITEMS = 500;
   localparam int unsigned HOLD_CYCLES  = 250;
   localparam int unsigned SETTLE       = 8;

   typedef struct {
      logic signed [FILT_W-1:0] filtered;
      logic [POS_W-1:0]         row;
      logic [POS_W-1:0]         col;
      logic                     last;
   } filter_result_type;

   class filter_scoreboard;
      logic [ROWREG_W-1:0]  coef_row [3];
      logic [SIZEREG_W-1:0] width_reg;
      logic [SIZEREG_W-1:0] height_reg;
      logic [PIXEL_W-1:0]   line_two [MAX_WIDTH];
      logic [PIXEL_W-1:0]   line_one [MAX_WIDTH];
      logic [PIXEL_W-1:0]   win [3][3];
      int unsigned          col_cnt;
      int unsigned          row_cnt;
      filter_result_type    expected_results [$];
      int                   errors;

      function new();
         foreach (coef_row[i]) coef_row[i] = '0;
         width_reg  = SIZEREG_W'(MAX_WIDTH);
         height_reg = SIZEREG_W'(MAX_HEIGHT);
         foreach (line_two[i]) begin
            line_two[i] = '0;
            line_one[i] = '0;
         end
         foreach (win[i, j]) win[i][j] = '0;
         col_cnt = 0;
         row_cnt = 0;
         errors  = 0;
      endfunction

      function int unsigned eff_size(logic [SIZEREG_W-1:0] v, int unsigned maxv);
         if (v < 3) return 3;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_COEF_TOP:    coef_row[0] = val[ROWREG_W-1:0];
            REG_COEF_MID:    coef_row[1] = val[ROWREG_W-1:0];
            REG_COEF_BOTTOM: coef_row[2] = val[ROWREG_W-1:0];
            REG_WIDTH:       width_reg   = val[SIZEREG_W-1:0];
            REG_HEIGHT:      height_reg  = val[SIZEREG_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(csr_index_type idx);
         case (idx)
            REG_COEF_TOP:    return CSR_DATA_W'(coef_row[0]);
            REG_COEF_MID:    return CSR_DATA_W'(coef_row[1]);
            REG_COEF_BOTTOM: return CSR_DATA_W'(coef_row[2]);
            REG_WIDTH:       return CSR_DATA_W'(width_reg);
            REG_HEIGHT:      return CSR_DATA_W'(height_reg);
            default:         return '0;
         endcase
      endfunction

      function bit at_image_start();
         return (col_cnt == 0) && (row_cnt == 0);
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] px);
         int unsigned       w;
         int unsigned       h;
         int unsigned       c;
         int unsigned       r;
         int unsigned       ci;
         int                sum;
         bit                row_end;
         bit                img_end;
         filter_result_type res;
         w  = eff_size(width_reg, MAX_WIDTH);
         h  = eff_size(height_reg, MAX_HEIGHT);
         c  = col_cnt;
         r  = row_cnt;
         ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2]    = line_two[ci];
         win[1][2]    = line_one[ci];
         win[2][2]    = px;
         line_two[ci] = line_one[ci];
         line_one[ci] = px;
         row_end = (c >= w - 1);
         img_end = row_end && (r >= h - 1);
         if (r >= 2 && c >= 2) begin
            sum = 0;
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  sum += int'(win[i][j]) * int'($signed(coef_row[i][COEF_W*j +: COEF_W]));
               end
            end
            res.filtered = FILT_W'(sum);
            res.row      = POS_W'(r - 1);
            res.col      = POS_W'(c - 1);
            res.last     = img_end;
            expected_results.push_back(res);
         end
         if (img_end) begin
            col_cnt = 0;
            row_cnt = 0;
         end else if (row_end) begin
            col_cnt = 0;
            row_cnt = r + 1;
         end else begin
            col_cnt = c + 1;
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("mismatch in %s: got %0d, expected %0d", what, got, want);
         errors++;
      endtask

      task check_value(string what, int got, int want);
         if (got != want) report_mismatch(what, got, want);
      endtask

      task check_result(filter_result_type got);
         filter_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending, col", got.col, 0);
         end else begin
            want = expected_results.pop_front();
            check_value("filtered", int'(got.filtered), int'(want.filtered));
            check_value("out_row", got.row, want.row);
            check_value("out_col", got.col, want.col);
            check_value("last", got.last, want.last);
         end
      endtask
   endclass

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [PIXEL_W-1:0]       req_pixel = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [FILT_W-1:0] rsp_filtered;
   logic [POS_W-1:0]         rsp_out_row;
   logic [POS_W-1:0]         rsp_out_col;
   logic                     rsp_last;
   logic                     psel      = 1'b0;
   logic                     penable   = 1'b0;
   logic                     pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr     = '0;
   logic [CSR_DATA_W-1:0]    pwdata    = '0;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   filter_scoreboard  sb = new();
   filter_result_type rsp_seen;
   int unsigned       gap_mode     = 0;
   bit                hold_pending = 1'b0;
   int unsigned       hold_left    = 0;
   int unsigned       stall_left   = 0;
   int unsigned       stall_pick;
   int unsigned       cycle_count  = 0;
   int unsigned       item_count   = 0;

   conv3x3_image_filter_unit u_top (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (gap_mode == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [ROWREG_W-1:0] pick_coef_row();
      case ($urandom_range(0, 7))
         0:       return 24'h808080;
         1:       return 24'h7F7F7F;
         default: return ROWREG_W'($urandom());
      endcase
   endfunction

   // result side: check accepted results, then decide the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen.filtered = rsp_filtered;
            rsp_seen.row      = rsp_out_row;
            rsp_seen.col      = rsp_out_col;
            rsp_seen.last     = rsp_last;
            sb.check_result(rsp_seen);
         end
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_pick = pick_gap();
            rsp_stall  <= (stall_pick > 0);
            stall_left = (stall_pick > 0) ? stall_pick - 1 : 0;
         end
      end
   end

   task send_pixel(logic [PIXEL_W-1:0] px);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(px);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(idx));
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, val);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task csr_read_check(csr_index_type idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * int'(idx));
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.check_value("register readback", prdata, sb.reg_value(idx));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task set_config(logic [ROWREG_W-1:0] top, logic [ROWREG_W-1:0] mid,
                   logic [ROWREG_W-1:0] bottom, int unsigned w, int unsigned h);
      csr_index_type idx;
      csr_write(REG_COEF_TOP, CSR_DATA_W'(top));
      csr_write(REG_COEF_MID, CSR_DATA_W'(mid));
      csr_write(REG_COEF_BOTTOM, CSR_DATA_W'(bottom));
      csr_write(REG_WIDTH, CSR_DATA_W'(w));
      csr_write(REG_HEIGHT, CSR_DATA_W'(h));
      idx = idx.first();
      do begin
         csr_read_check(idx);
         idx = idx.next();
      end while (idx != idx.first());
   endtask

   // sends pixels up to the end of the image; optional pause, optional resize at the pause
   task send_image(int unsigned pause_at, bit resize);
      int unsigned sent;
      int unsigned cur_w;
      sent = 0;
      do begin
         send_pixel(pick_pixel());
         sent++;
         if (pause_at != 0 && sent == pause_at && !sb.at_image_start()) begin
            drain();
            if (resize) begin
               cur_w = sb.eff_size(sb.width_reg, MAX_WIDTH);
               if ($urandom_range(0, 4) == 0) begin
                  csr_write(REG_WIDTH, CSR_DATA_W'($urandom_range(0, 2)));
               end else begin
                  csr_write(REG_WIDTH, CSR_DATA_W'($urandom_range(3, cur_w)));
               end
               csr_write(REG_HEIGHT, CSR_DATA_W'($urandom_range(0, 12)));
            end
         end
      end while (!sb.at_image_start());
      item_count += sent;
   endtask

   task run_random_phase();
      int unsigned w;
      int unsigned h;
      int unsigned pixels;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 32);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      set_config(pick_coef_row(), pick_coef_row(), pick_coef_row(), w, h);
      gap_mode = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 2)) begin
         pixels = sb.eff_size(sb.width_reg, MAX_WIDTH) * sb.eff_size(sb.height_reg, MAX_HEIGHT);
         if ($urandom_range(0, 2) == 0) begin
            send_image($urandom_range(1, pixels - 1), $urandom_range(0, 1));
         end else begin
            send_image(0, 1'b0);
         end
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // most negative and most positive sums on a minimal image
      gap_mode = 0;
      set_config(24'h808080, 24'h808080, 24'h808080, 3, 3);
      repeat (9) send_pixel(8'hFF);
      drain();
      set_config(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 3, 3);
      repeat (9) send_pixel(8'hFF);
      drain();

      // sizes below the low end, saturated
      gap_mode = 1;
      set_config(pick_coef_row(), pick_coef_row(), pick_coef_row(), 2, 0);
      send_image(0, 1'b0);
      drain();
      set_config(pick_coef_row(), pick_coef_row(), pick_coef_row(), 1, 2);
      send_image(0, 1'b0);
      drain();

      // long receiver hold while pixels keep coming, then a pause until drained
      gap_mode = 0;
      set_config(pick_coef_row(), pick_coef_row(), pick_coef_row(), 20, 16);
      hold_pending = 1'b1;
      send_image(160, 1'b0);
      drain();

      item_count = 0;
      while (item_count < RANDOM_ITEMS) run_random_phase();

      drain();
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
